// ===== design/scb_pkg.sv =====
// Shared types and constants for the snooping coherence bus core.
// Holds sizes, MESIF and transaction codes, channel payloads and the
// controller/datapath command and status structs. No dependencies.
package scb_pkg;

   localparam int NUM_CPUS        = 4;
   localparam int LINES_PER_CACHE = 4;
   localparam int MEM_CELLS       = 16;

   localparam int TOTAL_LINES = NUM_CPUS * LINES_PER_CACHE;
   localparam int LINE_IDX_W  = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
   localparam int SCAN_W      = $clog2(TOTAL_LINES + 1);
   localparam int MEM_IDX_W   = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

   localparam int FUNC_W = 2;
   localparam int CPU_W  = 2;
   localparam int ADDR_W = 4;
   localparam int VICT_W = 2;
   localparam int DATA_W = 8;
   localparam int STATE_W = 3;
   localparam int TOUCH_W = 2;

   typedef enum logic [STATE_W-1:0] {
      ST_I = 3'd0,
      ST_S = 3'd1,
      ST_E = 3'd2,
      ST_F = 3'd3,
      ST_M = 3'd4
   } mesif_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INVALIDATE = 2'd0,
      FUNC_READ       = 2'd1,
      FUNC_RWITM      = 2'd2
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CPU_W-1:0]  requester;
      logic [ADDR_W-1:0] line_address;
      logic [VICT_W-1:0] victim_line;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]  fill_data;
      logic [STATE_W-1:0] fill_state;
      logic               hit_other_cache;
      logic               wrote_back;
      logic [ADDR_W-1:0]  write_back_address;
      logic [TOUCH_W-1:0] copies_touched;
   } rsp_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] tag;
      logic [DATA_W-1:0] data;
      mesif_type         state;
   } line_type;

   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_VICTIM_RD,
      CTRL_WRITE_BACK,
      CTRL_SCAN,
      CTRL_MEM_RD,
      CTRL_FILL,
      CTRL_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic rd_victim;
      logic write_back;
      logic scan;
      logic mem_read;
      logic fill;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic new_bad;
      logic new_inval;
      logic is_inval;
      logic scan_done;
      logic out_busy;
   } ctrl_status_type;

endpackage

// ===== design/scb_if.sv =====
// Valid/ready channel interfaces for bus transactions and their results.
// Depends on scb_pkg for the payload types.
interface scb_req_if;
   logic                     valid;
   logic                     ready;
   scb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface scb_rsp_if;
   logic                     valid;
   logic                     ready;
   scb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/scb_ctrl.sv =====
// Sequencer for one bus transaction: victim read, write-back, snoop scan,
// memory read, fill and result hand-off. Depends on scb_pkg.
module scb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  scb_pkg::ctrl_status_type status,
   output scb_pkg::ctrl_cmd_type    cmd
);

   scb_pkg::ctrl_state_type state_ff;
   scb_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scb_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scb_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               if (status.new_bad) begin
                  state_in = scb_pkg::CTRL_DONE;
               end else if (status.new_inval) begin
                  state_in = scb_pkg::CTRL_SCAN;
               end else begin
                  state_in = scb_pkg::CTRL_VICTIM_RD;
               end
            end
         end
         scb_pkg::CTRL_VICTIM_RD:  state_in = scb_pkg::CTRL_WRITE_BACK;
         scb_pkg::CTRL_WRITE_BACK: state_in = scb_pkg::CTRL_SCAN;
         scb_pkg::CTRL_SCAN: begin
            if (status.scan_done) begin
               state_in = status.is_inval ? scb_pkg::CTRL_DONE : scb_pkg::CTRL_MEM_RD;
            end
         end
         scb_pkg::CTRL_MEM_RD: state_in = scb_pkg::CTRL_FILL;
         scb_pkg::CTRL_FILL:   state_in = scb_pkg::CTRL_DONE;
         scb_pkg::CTRL_DONE: begin
            if (!status.out_busy) begin
               state_in = scb_pkg::CTRL_IDLE;
            end
         end
         default: state_in = scb_pkg::CTRL_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         scb_pkg::CTRL_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         scb_pkg::CTRL_VICTIM_RD:  cmd.rd_victim  = 1'b1;
         scb_pkg::CTRL_WRITE_BACK: cmd.write_back = 1'b1;
         scb_pkg::CTRL_SCAN:       cmd.scan       = !status.scan_done;
         scb_pkg::CTRL_MEM_RD:     cmd.mem_read   = 1'b1;
         scb_pkg::CTRL_FILL:       cmd.fill       = 1'b1;
         scb_pkg::CTRL_DONE:       cmd.load_out   = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== design/scb_datapath.sv =====
// Cache line store, byte memory, snoop scan pipeline and result register.
// Driven by scb_ctrl commands; depends on scb_pkg.
module scb_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  scb_pkg::ctrl_cmd_type    cmd,
   output scb_pkg::ctrl_status_type status,
   input  scb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output scb_pkg::rsp_payload_type rsp_payload
);

   scb_pkg::line_type                  line_mem [scb_pkg::TOTAL_LINES];
   logic [scb_pkg::TOTAL_LINES-1:0]    line_valid_ff;
   logic [scb_pkg::DATA_W-1:0]         mem_cells [scb_pkg::MEM_CELLS];
   logic [scb_pkg::MEM_CELLS-1:0]      mem_valid_ff;

   scb_pkg::line_type                  line_q_ff;
   logic [scb_pkg::DATA_W-1:0]         mem_q_ff;

   logic [scb_pkg::FUNC_W-1:0]         func_ff;
   logic [scb_pkg::CPU_W-1:0]          req_ff;
   logic [scb_pkg::ADDR_W-1:0]         addr_ff;
   logic [scb_pkg::LINE_IDX_W-1:0]     victim_ff;

   logic [scb_pkg::SCAN_W-1:0]         scan_idx_ff;
   logic                               eval_valid_ff;
   logic [scb_pkg::LINE_IDX_W-1:0]     eval_idx_ff;
   logic                               found_ff;
   logic                               changed_ff;
   logic                               hit_ff;
   logic [scb_pkg::TOUCH_W-1:0]        touched_ff;
   logic [scb_pkg::DATA_W-1:0]         snoop_data_ff;
   logic                               wb_ff;
   logic [scb_pkg::ADDR_W-1:0]         wb_addr_ff;
   logic [scb_pkg::DATA_W-1:0]         fill_data_ff;
   logic [scb_pkg::STATE_W-1:0]        fill_state_ff;

   logic                               out_full_ff;
   scb_pkg::rsp_payload_type           out_ff;

   logic                               is_inval;
   logic                               issue_active;
   logic [scb_pkg::LINE_IDX_W-1:0]     rd_idx;
   logic                               rd_en;
   logic [scb_pkg::LINE_IDX_W-1:0]     new_victim;
   logic [scb_pkg::ADDR_W-1:0]         new_addr;

   logic                               first_line;
   logic                               last_line;
   logic                               own_cpu;
   logic                               tag_match;
   logic                               found_eff;
   logic                               changed_eff;
   logic                               upd;
   logic                               cur_change;
   logic                               hit_now;
   logic                               found_in;
   logic                               changed_in;
   scb_pkg::mesif_type                 snoop_state;
   scb_pkg::mesif_type                 upd_state;
   logic                               wb_needed;
   logic [scb_pkg::DATA_W-1:0]         fill_data;
   scb_pkg::mesif_type                 fill_state;

   assign is_inval     = (func_ff == scb_pkg::FUNC_INVALIDATE);
   assign issue_active = (scan_idx_ff < scb_pkg::SCAN_W'(scb_pkg::TOTAL_LINES));
   assign rd_en        = cmd.rd_victim || (cmd.scan && issue_active);
   assign rd_idx       = cmd.rd_victim ? victim_ff : scan_idx_ff[scb_pkg::LINE_IDX_W-1:0];

   assign new_addr   = scb_pkg::ADDR_W'(32'(req_payload.line_address) % scb_pkg::MEM_CELLS);
   assign new_victim = scb_pkg::LINE_IDX_W'(32'(req_payload.requester) * scb_pkg::LINES_PER_CACHE
                       + 32'(req_payload.victim_line) % scb_pkg::LINES_PER_CACHE);

   always_comb begin
      status.new_bad   = (req_payload.func != scb_pkg::FUNC_INVALIDATE) &&
                         (req_payload.func != scb_pkg::FUNC_READ) &&
                         (req_payload.func != scb_pkg::FUNC_RWITM) ||
                         (32'(req_payload.requester) >= scb_pkg::NUM_CPUS);
      status.new_inval = (req_payload.func == scb_pkg::FUNC_INVALIDATE);
      status.is_inval  = is_inval;
      status.scan_done = !issue_active && !eval_valid_ff;
      status.out_busy  = out_full_ff && !rsp_ready;
   end

   always_comb begin
      first_line  = (32'(eval_idx_ff) % scb_pkg::LINES_PER_CACHE) == 0;
      last_line   = (32'(eval_idx_ff) % scb_pkg::LINES_PER_CACHE)
                    == scb_pkg::LINES_PER_CACHE - 1;
      own_cpu     = (32'(eval_idx_ff) / scb_pkg::LINES_PER_CACHE) == 32'(req_ff);
      tag_match   = (line_q_ff.tag == addr_ff);
      found_eff   = found_ff && !first_line;
      changed_eff = changed_ff && !first_line;
      snoop_state = (func_ff == scb_pkg::FUNC_READ) ? scb_pkg::ST_S : scb_pkg::ST_I;
      upd         = 1'b0;
      upd_state   = scb_pkg::ST_I;
      cur_change  = 1'b0;
      hit_now     = 1'b0;
      if (eval_valid_ff && !own_cpu) begin
         if (is_inval) begin
            if (tag_match && !found_eff) begin
               upd        = 1'b1;
               cur_change = (line_q_ff.state != scb_pkg::ST_I);
               hit_now    = cur_change;
            end
         end else if (tag_match && line_q_ff.state != scb_pkg::ST_I) begin
            upd        = 1'b1;
            upd_state  = snoop_state;
            cur_change = (line_q_ff.state != snoop_state);
            hit_now    = 1'b1;
         end
      end
      found_in   = found_eff || upd;
      changed_in = changed_eff || cur_change;
   end

   always_comb begin
      wb_needed  = (line_q_ff.state == scb_pkg::ST_F) || (line_q_ff.state == scb_pkg::ST_M);
      fill_data  = hit_ff ? snoop_data_ff : mem_q_ff;
      fill_state = hit_ff ? scb_pkg::ST_F : scb_pkg::ST_E;
      if (func_ff == scb_pkg::FUNC_RWITM) begin
         fill_data  = fill_data + scb_pkg::DATA_W'(1);
         fill_state = scb_pkg::ST_M;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         line_q_ff <= line_valid_ff[rd_idx] ? line_mem[rd_idx] : '0;
      end
      if (upd) begin
         line_mem[eval_idx_ff] <= '{tag: line_q_ff.tag, data: line_q_ff.data,
                                    state: upd_state};
      end else if (cmd.fill) begin
         line_mem[victim_ff] <= '{tag: addr_ff, data: fill_data, state: fill_state};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         mem_q_ff <= mem_valid_ff[scb_pkg::MEM_IDX_W'(addr_ff)]
                     ? mem_cells[scb_pkg::MEM_IDX_W'(addr_ff)] : '0;
      end
      if (cmd.write_back && wb_needed) begin
         mem_cells[scb_pkg::MEM_IDX_W'(line_q_ff.tag)] <= line_q_ff.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         mem_valid_ff  <= '0;
         eval_valid_ff <= 1'b0;
         scan_idx_ff   <= '0;
         out_full_ff   <= 1'b0;
      end else begin
         if (upd) begin
            line_valid_ff[eval_idx_ff] <= 1'b1;
         end else if (cmd.fill) begin
            line_valid_ff[victim_ff] <= 1'b1;
         end
         if (cmd.write_back && wb_needed) begin
            mem_valid_ff[scb_pkg::MEM_IDX_W'(line_q_ff.tag)] <= 1'b1;
         end
         if (cmd.accept) begin
            scan_idx_ff   <= '0;
            eval_valid_ff <= 1'b0;
         end else if (cmd.scan && issue_active) begin
            scan_idx_ff   <= scan_idx_ff + scb_pkg::SCAN_W'(1);
            eval_valid_ff <= 1'b1;
         end else begin
            eval_valid_ff <= 1'b0;
         end
         if (cmd.load_out) begin
            out_full_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && issue_active) begin
         eval_idx_ff <= scan_idx_ff[scb_pkg::LINE_IDX_W-1:0];
      end
      if (cmd.accept) begin
         func_ff       <= req_payload.func;
         req_ff        <= req_payload.requester;
         addr_ff       <= new_addr;
         victim_ff     <= new_victim;
         found_ff      <= 1'b0;
         changed_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         touched_ff    <= '0;
         snoop_data_ff <= '0;
         wb_ff         <= 1'b0;
         wb_addr_ff    <= '0;
         fill_data_ff  <= '0;
         fill_state_ff <= scb_pkg::ST_I;
      end else begin
         if (eval_valid_ff) begin
            found_ff   <= found_in;
            changed_ff <= changed_in;
            if (last_line && changed_in && touched_ff != '1) begin
               touched_ff <= touched_ff + scb_pkg::TOUCH_W'(1);
            end
         end
         if (hit_now) begin
            hit_ff <= 1'b1;
         end
         if (upd && !is_inval) begin
            snoop_data_ff <= line_q_ff.data;
         end
         if (cmd.write_back && wb_needed) begin
            wb_ff      <= 1'b1;
            wb_addr_ff <= line_q_ff.tag;
         end
         if (cmd.fill) begin
            fill_data_ff  <= fill_data;
            fill_state_ff <= fill_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff.fill_data          <= fill_data_ff;
         out_ff.fill_state         <= fill_state_ff;
         out_ff.hit_other_cache    <= hit_ff;
         out_ff.wrote_back         <= wb_ff;
         out_ff.write_back_address <= wb_addr_ff;
         out_ff.copies_touched     <= touched_ff;
      end
   end

   assign rsp_valid   = out_full_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_touched_implies_hit: assert property (@(posedge clock) disable iff (reset)
      out_full_ff |-> (out_ff.copies_touched == '0) || out_ff.hit_other_cache)
      else $error("copies touched without a snoop hit");

   a_wb_addr_zero: assert property (@(posedge clock) disable iff (reset)
      out_full_ff && !out_ff.wrote_back |-> out_ff.write_back_address == '0)
      else $error("write-back address set without a write-back");

   a_eval_follows_issue: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> $past(cmd.scan))
      else $error("snoop evaluation without a preceding line read");
`endif

endmodule

// ===== design/snooping_coherence_bus_core.sv =====
// Snooping coherence bus core: one bus transaction per request transfer,
// one result transfer per request. A transaction runs alone. The snoop scan
// reads one cache line per cycle through the single read port of the line
// store. A reserved function or an out-of-range requester returns an all-zero
// result without a scan. The result waits in an output register, and the
// next request is taken in the cycle after the result is loaded. A result
// still held with no ready holds the load of the next one. Depends on scb_pkg,
// scb_if, scb_ctrl and scb_datapath.
module snooping_coherence_bus_core (
   input  logic         clock,
   input  logic         reset,
   scb_req_if.sink      req_bus,
   scb_rsp_if.source    rsp_bus
);

   scb_pkg::ctrl_cmd_type    cmd;
   scb_pkg::ctrl_status_type status;

   scb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_bus.payload),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for snooping_coherence_bus_core: directed and random
// bus transactions, a cache and memory mirror that predicts each result.
// Depends on scb_pkg, scb_if and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [scb_pkg::FUNC_W-1:0] FUNC_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;

   class coherence_mirror;
      logic [scb_pkg::ADDR_W-1:0] tag_q   [scb_pkg::TOTAL_LINES];
      logic [scb_pkg::DATA_W-1:0] data_q  [scb_pkg::TOTAL_LINES];
      scb_pkg::mesif_type         state_q [scb_pkg::TOTAL_LINES];
      logic [scb_pkg::DATA_W-1:0] cell_q  [scb_pkg::MEM_CELLS];
      scb_pkg::rsp_payload_type   pending_fills [$];
      int errors;
      int requests;
      int results;
      int write_backs;
      int snoop_hits;

      function new();
         foreach (tag_q[k]) begin
            tag_q[k]   = '0;
            data_q[k]  = '0;
            state_q[k] = scb_pkg::ST_I;
         end
         foreach (cell_q[k]) cell_q[k] = '0;
         errors      = 0;
         requests    = 0;
         results     = 0;
         write_backs = 0;
         snoop_hits  = 0;
      endfunction

      function scb_pkg::rsp_payload_type predict_fill(scb_pkg::req_payload_type t);
         scb_pkg::rsp_payload_type   r;
         scb_pkg::mesif_type         snoop_state;
         logic [scb_pkg::DATA_W-1:0] d;
         logic hit;
         logic changed;
         int   touched;
         int   req;
         int   addr;
         int   v;
         int   k;
         int   wb_addr;
         r       = '0;
         hit     = 1'b0;
         touched = 0;
         d       = '0;
         req     = int'(t.requester);
         addr    = int'(t.line_address) % scb_pkg::MEM_CELLS;
         if (t.func == FUNC_RESERVED || req >= scb_pkg::NUM_CPUS) return r;
         if (t.func == scb_pkg::FUNC_INVALIDATE) begin
            for (int c = 0; c < scb_pkg::NUM_CPUS; c++) begin
               if (c == req) continue;
               for (int l = 0; l < scb_pkg::LINES_PER_CACHE; l++) begin
                  k = c * scb_pkg::LINES_PER_CACHE + l;
                  if (int'(tag_q[k]) == addr) begin
                     if (state_q[k] != scb_pkg::ST_I) begin
                        hit = 1'b1;
                        touched++;
                     end
                     state_q[k] = scb_pkg::ST_I;
                     break;
                  end
               end
            end
            r.hit_other_cache = hit;
            r.copies_touched  = scb_pkg::TOUCH_W'((touched > 3) ? 3 : touched);
            return r;
         end
         v = req * scb_pkg::LINES_PER_CACHE + int'(t.victim_line) % scb_pkg::LINES_PER_CACHE;
         if (state_q[v] == scb_pkg::ST_F || state_q[v] == scb_pkg::ST_M) begin
            wb_addr = int'(tag_q[v]) % scb_pkg::MEM_CELLS;
            cell_q[wb_addr]      = data_q[v];
            r.wrote_back         = 1'b1;
            r.write_back_address = scb_pkg::ADDR_W'(wb_addr);
         end
         snoop_state = (t.func == scb_pkg::FUNC_READ) ? scb_pkg::ST_S : scb_pkg::ST_I;
         for (int c = 0; c < scb_pkg::NUM_CPUS; c++) begin
            if (c == req) continue;
            changed = 1'b0;
            for (int l = 0; l < scb_pkg::LINES_PER_CACHE; l++) begin
               k = c * scb_pkg::LINES_PER_CACHE + l;
               if (int'(tag_q[k]) == addr && state_q[k] != scb_pkg::ST_I) begin
                  if (state_q[k] != snoop_state) changed = 1'b1;
                  state_q[k] = snoop_state;
                  d   = data_q[k];
                  hit = 1'b1;
               end
            end
            if (changed) touched++;
         end
         if (!hit) d = cell_q[addr];
         if (t.func == scb_pkg::FUNC_READ) begin
            r.fill_state = hit ? scb_pkg::ST_F : scb_pkg::ST_E;
         end else begin
            d = d + scb_pkg::DATA_W'(1);
            r.fill_state = scb_pkg::ST_M;
         end
         tag_q[v]   = scb_pkg::ADDR_W'(addr);
         data_q[v]  = d;
         state_q[v] = scb_pkg::mesif_type'(r.fill_state);
         r.fill_data       = d;
         r.hit_other_cache = hit;
         r.copies_touched  = scb_pkg::TOUCH_W'((touched > 3) ? 3 : touched);
         return r;
      endfunction

      function void note_request(scb_pkg::req_payload_type t);
         pending_fills = {pending_fills, predict_fill(t)};
         requests++;
      endfunction

      function int outstanding();
         return pending_fills.size();
      endfunction

      task report(string field, int got, int want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
         errors++;
      endtask

      task check_result(scb_pkg::rsp_payload_type got);
         scb_pkg::rsp_payload_type want;
         results++;
         if (pending_fills.size() == 0) begin
            report("unexpected result transfer", int'(got), 0);
            return;
         end
         want = pending_fills.pop_front();
         if (got.wrote_back) write_backs++;
         if (got.hit_other_cache) snoop_hits++;
         if (got.fill_data !== want.fill_data)
            report("fill_data", int'(got.fill_data), int'(want.fill_data));
         if (got.fill_state !== want.fill_state)
            report("fill_state", int'(got.fill_state), int'(want.fill_state));
         if (got.hit_other_cache !== want.hit_other_cache)
            report("hit_other_cache", int'(got.hit_other_cache),
                   int'(want.hit_other_cache));
         if (got.wrote_back !== want.wrote_back)
            report("wrote_back", int'(got.wrote_back), int'(want.wrote_back));
         if (got.write_back_address !== want.write_back_address)
            report("write_back_address", int'(got.write_back_address),
                   int'(want.write_back_address));
         if (got.copies_touched !== want.copies_touched)
            report("copies_touched", int'(got.copies_touched), int'(want.copies_touched));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_burst;
   logic rsp_burst;

   scb_req_if req_bus ();
   scb_rsp_if rsp_bus ();

   coherence_mirror mirror = new();

   snooping_coherence_bus_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap(logic burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic scb_pkg::req_payload_type make_req(logic [scb_pkg::FUNC_W-1:0] f,
                                                         int c, int a, int v);
      scb_pkg::req_payload_type t;
      t.func         = f;
      t.requester    = scb_pkg::CPU_W'(c);
      t.line_address = scb_pkg::ADDR_W'(a);
      t.victim_line  = scb_pkg::VICT_W'(v);
      return t;
   endfunction

   task automatic send_item(scb_pkg::req_payload_type t, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.payload <= t;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      mirror.note_request(t);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (mirror.outstanding() > 0);
   endtask

   initial begin
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      forever begin
         repeat ($urandom_range(100, 600)) @(posedge clock);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap(rsp_burst);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         mirror.check_result(rsp_bus.payload);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
               mirror.outstanding());
      $display("[snooping_coherence_bus_core] ERROR");
      $finish;
   end

   initial begin
      scb_pkg::req_payload_type   t;
      logic [scb_pkg::ADDR_W-1:0] hot_addr;
      logic [scb_pkg::ADDR_W-1:0] window_base;
      int r;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_req(scb_pkg::FUNC_INVALIDATE, 0, 0, 0), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 0, 0, 0), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 1, 0, 1), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 2, 0, 2), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_RWITM, 3, 0, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 3, 5, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 0, 5, 1), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 2, 5, 2), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_INVALIDATE, 1, 5, 0), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_RWITM, 0, 15, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_RWITM, 1, 15, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_RWITM, 2, 15, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 3, 15, 0), pick_gap(1'b0));
      send_item(make_req(FUNC_RESERVED, 2, 15, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 1, 15, 3), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_INVALIDATE, 3, 15, 2), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 0, 10, 3), pick_gap(1'b0));
      send_item(make_req(FUNC_RESERVED, 3, 0, 0), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_RWITM, 3, 10, 1), pick_gap(1'b0));
      send_item(make_req(scb_pkg::FUNC_READ, 2, 10, 0), pick_gap(1'b0));
      drain_results();

      hot_addr    = scb_pkg::ADDR_W'($urandom_range(0, scb_pkg::MEM_CELLS - 1));
      window_base = scb_pkg::ADDR_W'($urandom_range(0, scb_pkg::MEM_CELLS - 1));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 199) begin
            window_base = scb_pkg::ADDR_W'($urandom_range(0, scb_pkg::MEM_CELLS - 1));
         end
         r = $urandom_range(0, 99);
         if (r < 15)      t.func = scb_pkg::FUNC_INVALIDATE;
         else if (r < 20) t.func = FUNC_RESERVED;
         else if (r < 60) t.func = scb_pkg::FUNC_READ;
         else             t.func = scb_pkg::FUNC_RWITM;
         r = $urandom_range(0, 99);
         if (r < 30) begin
            t.line_address = hot_addr;
         end else if (r < 75) begin
            t.line_address = window_base + scb_pkg::ADDR_W'($urandom_range(0, 3));
         end else begin
            t.line_address = scb_pkg::ADDR_W'($urandom_range(0, scb_pkg::MEM_CELLS - 1));
         end
         t.requester   = scb_pkg::CPU_W'($urandom_range(0, scb_pkg::NUM_CPUS - 1));
         t.victim_line = scb_pkg::VICT_W'($urandom_range(0, 3));
         if ($urandom_range(0, 99) == 0) drain_results();
         send_item(t, pick_gap(req_burst));
      end
      req_bus.valid <= 1'b0;

      while (mirror.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions and %0d results", mirror.requests, mirror.results);
      $display("with %0d write-backs and %0d snoop hits, %0d mismatches",
               mirror.write_backs, mirror.snoop_hits, mirror.errors);
      if (mirror.errors == 0 && mirror.outstanding() == 0) begin
         $display("[snooping_coherence_bus_core] OK");
      end else begin
         $display("[snooping_coherence_bus_core] ERROR");
      end
      $finish;
   end
endmodule
